/* design/lcd_escape_command_parser_defines.svh */
// Assertion macros for the escape command parser.
`ifndef LCD_ESCAPE_COMMAND_PARSER_DEFINES_SVH
`define LCD_ESCAPE_COMMAND_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCD_ESC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCD_ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/lcd_esc_pkg.sv */
// Shared types and constants of the escape command parser.
`timescale 1ns / 1ps

package lcd_esc_pkg;

   localparam logic [7:0] ESC_BYTE = 8'h1B;
   localparam logic [7:0] LETTER_CLEAR = 8'h63;
   localparam logic [7:0] LETTER_HOME = 8'h68;
   localparam logic [7:0] LETTER_CURSOR = 8'h70;
   localparam logic [7:0] LETTER_LEDS = 8'h6C;
   localparam logic [7:0] LETTER_GLYPH = 8'h75;

   localparam logic [2:0] KIND_CHAR = 3'd0;
   localparam logic [2:0] KIND_CLEAR = 3'd1;
   localparam logic [2:0] KIND_HOME = 3'd2;
   localparam logic [2:0] KIND_CURSOR = 3'd3;
   localparam logic [2:0] KIND_LEDS = 3'd4;
   localparam logic [2:0] KIND_GLYPH = 3'd5;

   localparam int ARG_DEPTH = 9;
   localparam int ARG_AW = 4;

   localparam logic [3:0] ARGS_CURSOR = 4'd4;
   localparam logic [3:0] ARGS_LEDS = 4'd2;
   localparam logic [3:0] ARGS_GLYPH = 4'd9;

   typedef struct packed {
      logic              en;
      logic [ARG_AW-1:0] addr;
      logic [7:0]        data;
   } arg_wr_type;

endpackage

/* design/lcd_escape_command_parser.sv */
// Top level of the escape command parser: byte intake, sequencer and result register.
// A plain byte, clear or home gives its single result in the cycle after the request.
// Cursor and LED commands decode their hex digits one per cycle (four or two digits)
// through the shared hex decoder; a glyph command decodes its single index digit and
// then emits ten results, one per cycle while the result side does not stall.
// The next request is taken in the cycle after the last result is accepted; synchronous reset clears to idle.
`timescale 1ns / 1ps
`include "lcd_escape_command_parser_defines.svh"

module lcd_escape_command_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_cmd_kind,
   output logic [7:0] rsp_value,
   output logic [3:0] rsp_pos_x,
   output logic [3:0] rsp_pos_y,
   output logic [3:0] rsp_cursor_on,
   output logic [3:0] rsp_blink_on,
   output logic       rsp_last
);
   import lcd_esc_pkg::*;

   typedef enum logic [1:0] {ST_READY, ST_DECODE, ST_OUT} state_type;
   typedef enum logic [1:0] {PH_IDLE, PH_ESC, PH_COLLECT} phase_type;

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [3:0]        remaining_ff, remaining_in;
   logic [7:0]        letter_ff, letter_in;
   logic [ARG_AW-1:0] idx_ff, idx_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [11:0]       acc_ff, acc_in;
   logic              rows_done_ff, rows_done_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        kind_ff, kind_in;
   logic [7:0]        value_ff, value_in;
   logic [15:0]       cur_ff, cur_in;
   logic              last_ff, last_in;

   arg_wr_type        arg_wr;
   logic [7:0]        rd_data;
   logic [3:0]        nib;
   logic [3:0]        rem_dec;

   lcd_esc_argbuf u_argbuf (
      .clock   (clock),
      .wr      (arg_wr),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   lcd_esc_hexdec u_hexdec (
      .ch  (rd_data),
      .nib (nib)
   );

   assign req_stall = (state_ff != ST_READY);
   assign rem_dec = remaining_ff - 4'd1;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      remaining_in = remaining_ff;
      letter_in = letter_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      rows_done_in = rows_done_ff;
      rsp_valid_in = rsp_valid_ff;
      kind_in = kind_ff;
      value_in = value_ff;
      cur_in = cur_ff;
      last_in = last_ff;
      arg_wr = '0;

      unique case (state_ff)
         ST_READY: begin
            if (req_valid) begin
               kind_in = KIND_CHAR;
               value_in = 8'd0;
               cur_in = 16'd0;
               last_in = 1'b1;
               unique case (phase_ff)
                  PH_ESC: begin
                     letter_in = req_rx_byte;
                     unique case (req_rx_byte)
                        LETTER_CLEAR: begin
                           kind_in = KIND_CLEAR;
                           rsp_valid_in = 1'b1;
                           state_in = ST_OUT;
                           phase_in = PH_IDLE;
                        end
                        LETTER_HOME: begin
                           kind_in = KIND_HOME;
                           rsp_valid_in = 1'b1;
                           state_in = ST_OUT;
                           phase_in = PH_IDLE;
                        end
                        LETTER_CURSOR: begin
                           remaining_in = ARGS_CURSOR;
                           phase_in = PH_COLLECT;
                        end
                        LETTER_LEDS: begin
                           remaining_in = ARGS_LEDS;
                           phase_in = PH_COLLECT;
                        end
                        LETTER_GLYPH: begin
                           remaining_in = ARGS_GLYPH;
                           phase_in = PH_COLLECT;
                        end
                        default: begin
                           phase_in = PH_ESC;
                        end
                     endcase
                  end
                  PH_COLLECT: begin
                     if (remaining_ff != 4'd0) begin
                        remaining_in = rem_dec;
                        arg_wr.en = 1'b1;
                        arg_wr.addr = rem_dec[ARG_AW-1:0];
                        arg_wr.data = req_rx_byte;
                     end
                     if ((remaining_ff == 4'd0) || (rem_dec == 4'd0)) begin
                        phase_in = PH_IDLE;
                        unique case (letter_ff)
                           LETTER_CURSOR: begin
                              idx_in = ARG_AW'(3);
                              cnt_in = 3'd4;
                              state_in = ST_DECODE;
                           end
                           LETTER_LEDS: begin
                              idx_in = ARG_AW'(1);
                              cnt_in = 3'd2;
                              state_in = ST_DECODE;
                           end
                           LETTER_GLYPH: begin
                              idx_in = ARG_AW'(8);
                              cnt_in = 3'd1;
                              state_in = ST_DECODE;
                           end
                           default: begin
                              state_in = ST_READY;
                           end
                        endcase
                     end
                  end
                  default: begin
                     if (req_rx_byte == ESC_BYTE) begin
                        phase_in = PH_ESC;
                     end else begin
                        phase_in = PH_IDLE;
                        kind_in = KIND_CHAR;
                        value_in = req_rx_byte;
                        rsp_valid_in = 1'b1;
                        state_in = ST_OUT;
                     end
                  end
               endcase
            end
         end
         ST_DECODE: begin
            acc_in = {acc_ff[7:0], nib};
            idx_in = idx_ff - ARG_AW'(1);
            cnt_in = cnt_ff - 3'd1;
            if (cnt_ff == 3'd1) begin
               state_in = ST_OUT;
               rsp_valid_in = 1'b1;
               cur_in = 16'd0;
               value_in = 8'd0;
               last_in = 1'b1;
               rows_done_in = 1'b0;
               unique case (letter_ff)
                  LETTER_CURSOR: begin
                     kind_in = KIND_CURSOR;
                     cur_in = {acc_ff, nib};
                  end
                  LETTER_LEDS: begin
                     kind_in = KIND_LEDS;
                     value_in = {acc_ff[3:0], nib};
                  end
                  default: begin
                     kind_in = KIND_GLYPH;
                     value_in = {1'b0, nib, 3'b000};
                     last_in = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            if (!rsp_stall) begin
               cur_in = 16'd0;
               value_in = 8'd0;
               if (last_ff) begin
                  rsp_valid_in = 1'b0;
                  state_in = ST_READY;
               end else if (rows_done_ff) begin
                  kind_in = KIND_CURSOR;
                  last_in = 1'b1;
               end else begin
                  kind_in = KIND_CHAR;
                  value_in = rd_data;
                  last_in = 1'b0;
                  rows_done_in = (idx_ff == ARG_AW'(0));
                  idx_in = idx_ff - ARG_AW'(1);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_READY;
         phase_ff <= PH_IDLE;
         remaining_ff <= 4'd0;
         letter_ff <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         remaining_ff <= remaining_in;
         letter_ff <= letter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      rows_done_ff <= rows_done_in;
      kind_ff <= kind_in;
      value_ff <= value_in;
      cur_ff <= cur_in;
      last_ff <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cmd_kind = kind_ff;
   assign rsp_value = value_ff;
   assign rsp_pos_x = cur_ff[15:12];
   assign rsp_pos_y = cur_ff[11:8];
   assign rsp_cursor_on = cur_ff[7:4];
   assign rsp_blink_on = cur_ff[3:0];
   assign rsp_last = last_ff;

   `LCD_ESC_ASSERT_NOW(a_no_req_while_rsp, !req_stall, !rsp_valid, "open while result pending")
   `LCD_ESC_ASSERT_NEXT(a_ready_next, rsp_valid && rsp_last && !rsp_stall, !req_stall, "not ready")
   `LCD_ESC_ASSERT_NOW(a_decode_quiet, state_ff == ST_DECODE, !rsp_valid, "valid in decode")
endmodule

/* design/lcd_esc_hexdec.sv */
// Hex digit decoder shared by all argument decoding steps.
`timescale 1ns / 1ps

module lcd_esc_hexdec (
   input  logic [7:0] ch,
   output logic [3:0] nib
);
   always_comb begin
      nib = 4'd0;
      unique if (ch >= 8'h30 && ch <= 8'h39) begin
         nib = 4'(ch - 8'h30);
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         nib = 4'(ch - 8'h37);
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         nib = 4'(ch - 8'h57);
      end else begin
         nib = 4'd0;
      end
   end
endmodule

/* design/lcd_esc_argbuf.sv */
// Argument byte store with one write port and one read port.
`timescale 1ns / 1ps

module lcd_esc_argbuf (
   input  logic                           clock,
   input  lcd_esc_pkg::arg_wr_type        wr,
   input  logic [lcd_esc_pkg::ARG_AW-1:0] rd_addr,
   output logic [7:0]                     rd_data
);
   import lcd_esc_pkg::*;

   logic [7:0] arg_ff [ARG_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en && (32'(wr.addr) < ARG_DEPTH)) begin
         arg_ff[wr.addr] <= wr.data;
      end
   end

   always_comb begin
      rd_data = 8'd0;
      if (32'(rd_addr) < ARG_DEPTH) begin
         rd_data = arg_ff[rd_addr];
      end
   end
endmodule
